// ===== design/vsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_pkg
// Widths, register indexes, reset values and sideband types shared by the
// specular vertex lighting pipeline.
// ----------------------------------------------------------------------------
package vsa_pkg;

   localparam int POS_W    = 25;            // Q16.8 positions
   localparam int NORM_W   = 16;            // Q1.14 normals
   localparam int FRAC_W   = 14;            // fraction bits of unit vectors
   localparam int ALPHA_W  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_COUNT = 6;

   localparam int DIFF_W   = POS_W + 1;     // light - pos, eye - pos
   localparam int SQ_W     = 2 * DIFF_W;    // sum of three squares
   localparam int ROOT_W   = SQ_W / 2;
   localparam int LQ_W     = FRAC_W + 1;    // |L| <= 2^14
   localparam int LDIV_W   = ROOT_W + LQ_W;
   localparam int LV_W     = 16;            // signed L component
   localparam int PN_W     = NORM_W + LV_W;
   localparam int DSUM_W   = PN_W + 1;
   localparam int NL_W     = DSUM_W - FRAC_W;   // d = N.L
   localparam int ND_W     = NORM_W + NL_W;
   localparam int R_W      = ND_W - (FRAC_W - 1);
   localparam int RV_W     = R_W + DIFF_W;
   localparam int DOT_W    = RV_W + 2;
   localparam int AQ_W     = FRAC_W;        // unsaturated l is below 2^14
   localparam int ADIV_W   = ROOT_W + AQ_W;
   localparam int L2_W     = 2 * AQ_W;
   localparam int L4_W     = 2 * L2_W;
   localparam int SCALE_W  = L4_W + ALPHA_W;

   localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

   localparam logic signed [POS_W-1:0] LIGHT_X_RESET = -25'sd245760;
   localparam logic signed [POS_W-1:0] LIGHT_Y_RESET = 25'sd506880;
   localparam logic signed [POS_W-1:0] LIGHT_Z_RESET = 25'sd24576;
   localparam logic signed [POS_W-1:0] EYE_RESET     = 25'sd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X = 3'd0,
      CSR_LIGHT_Y = 3'd1,
      CSR_LIGHT_Z = 3'd2,
      CSR_EYE_X   = 3'd3,
      CSR_EYE_Y   = 3'd4,
      CSR_EYE_Z   = 3'd5
   } csr_index_type;

   // Sideband that rides along the square root stages.
   typedef struct packed {
      logic                        valid;
      logic                        last;
      logic [2:0][DIFF_W-1:0]      ld;
      logic [2:0][DIFF_W-1:0]      vv;
      logic [2:0][NORM_W-1:0]      norm;
   } side1_type;

   // Sideband that rides along the light normalization dividers.
   typedef struct packed {
      logic                        valid;
      logic                        last;
      logic [2:0]                  neg;
      logic                        szero;
      logic [2:0][DIFF_W-1:0]      vv;
      logic [2:0][NORM_W-1:0]      norm;
      logic [ROOT_W-1:0]           q;
   } side2_type;

   // Sideband that rides along the final divider and the power stages.
   typedef struct packed {
      logic                        valid;
      logic                        last;
      logic                        pos;
      logic                        sat;
   } side3_type;

endpackage
`default_nettype wire

// ===== design/vsa_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module vsa_isqrt #(
   parameter int IN_W = 52
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     radicand,
   output logic [IN_W/2-1:0]   root
);

   localparam int ROOT_W = IN_W / 2;
   localparam int RW     = ROOT_W + 3;

   logic [IN_W-1:0]   x_ff    [ROOT_W];
   logic [RW-1:0]     rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [IN_W-1:0]   x_prev;
      logic [RW-1:0]     rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RW-1:0]     rem_sh;
      logic [RW-1:0]     trial;
      logic              take;

      if (k == 0) begin : g_first
         assign x_prev    = radicand;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign x_prev    = x_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      assign rem_sh = {rem_prev[RW-3:0], x_prev[IN_W-1:IN_W-2]};
      assign trial  = RW'({root_prev, 2'b01});
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_prev << 2;
            rem_ff[k]  <= take ? (rem_sh - trial) : rem_sh;
            root_ff[k] <= {root_prev[ROOT_W-2:0], take};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

// ===== design/vsa_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vsa_div
// Pipelined unsigned restoring divider, one quotient bit per register stage.
// The dividend must be below divisor * 2^Q_W.
// ----------------------------------------------------------------------------
module vsa_div #(
   parameter int D_W = 26,
   parameter int Q_W = 14
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [D_W+Q_W-1:0]   dividend,
   input  logic [D_W-1:0]       divisor,
   output logic [Q_W-1:0]       quotient
);

   localparam int CW = D_W + Q_W;

   logic [CW-1:0]  rem_ff [Q_W];
   logic [D_W-1:0] div_ff [Q_W];
   logic [Q_W-1:0] quo_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int J = Q_W - 1 - k;
      logic [CW-1:0]  rem_prev;
      logic [D_W-1:0] div_prev;
      logic [Q_W-1:0] quo_prev;
      logic [CW-1:0]  dsh;
      logic           take;

      if (k == 0) begin : g_first
         assign rem_prev = dividend;
         assign div_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign div_prev = div_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign dsh  = CW'(div_prev) << J;
      assign take = (rem_prev >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? (rem_prev - dsh) : rem_prev;
            div_ff[k] <= div_prev;
            quo_ff[k] <= {quo_prev[Q_W-2:0], take};
         end
      end
   end

   assign quotient = quo_ff[Q_W-1];

endmodule
`default_nettype wire

// ===== design/vertex_specular_alpha_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_specular_alpha_core
// Per-vertex Phong specular coefficient written to the alpha channel.
// ----------------------------------------------------------------------------
// The core takes one vertex per clock while req_stall is low and returns one
// item per vertex, in order. The pipeline is made of the two bit-per-stage
// square roots (26 stages), the light normalizing dividers (15 stages), the
// final divide by |V| (14 stages) and the multiply stages around them. A
// two-entry output register and skid stage let the pipeline keep taking
// vertices while one result waits.
// Registers are plain writes and should only change while no vertex is in
// flight.
module vertex_specular_alpha_core import vsa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [POS_W-1:0]     req_pos_x,
   input  logic signed [POS_W-1:0]     req_pos_y,
   input  logic signed [POS_W-1:0]     req_pos_z,
   input  logic signed [NORM_W-1:0]    req_norm_x,
   input  logic signed [NORM_W-1:0]    req_norm_y,
   input  logic signed [NORM_W-1:0]    req_norm_z,
   input  logic                        req_last_in,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ALPHA_W-1:0]          rsp_spec_alpha,
   output logic                        rsp_last_out,

   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [POS_W-1:0]            csr_wdata
);

   // ---------------------------------------------------------------- csr
   logic signed [POS_W-1:0] csr_ff [CSR_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff[CSR_LIGHT_X] <= LIGHT_X_RESET;
         csr_ff[CSR_LIGHT_Y] <= LIGHT_Y_RESET;
         csr_ff[CSR_LIGHT_Z] <= LIGHT_Z_RESET;
         csr_ff[CSR_EYE_X]   <= EYE_RESET;
         csr_ff[CSR_EYE_Y]   <= EYE_RESET;
         csr_ff[CSR_EYE_Z]   <= EYE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LIGHT_X: csr_ff[CSR_LIGHT_X] <= csr_wdata;
            CSR_LIGHT_Y: csr_ff[CSR_LIGHT_Y] <= csr_wdata;
            CSR_LIGHT_Z: csr_ff[CSR_LIGHT_Z] <= csr_wdata;
            CSR_EYE_X:   csr_ff[CSR_EYE_X]   <= csr_wdata;
            CSR_EYE_Y:   csr_ff[CSR_EYE_Y]   <= csr_wdata;
            CSR_EYE_Z:   csr_ff[CSR_EYE_Z]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline advances unless the skid stage holds an item.
   logic en;
   logic skid_valid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------------------------------------------------------- S1
   logic signed [POS_W-1:0]  req_pos  [3];
   logic signed [NORM_W-1:0] req_norm [3];
   side1_type                s1_side_in;
   side1_type                s1_side_ff;

   always_comb begin
      req_pos[0]  = req_pos_x;
      req_pos[1]  = req_pos_y;
      req_pos[2]  = req_pos_z;
      req_norm[0] = req_norm_x;
      req_norm[1] = req_norm_y;
      req_norm[2] = req_norm_z;
      s1_side_in.valid = req_valid;
      s1_side_in.last  = req_last_in;
      for (int i = 0; i < 3; i++) begin
         s1_side_in.ld[i]   = DIFF_W'(csr_ff[i]) - DIFF_W'(req_pos[i]);
         s1_side_in.vv[i]   = DIFF_W'(csr_ff[3+i]) - DIFF_W'(req_pos[i]);
         s1_side_in.norm[i] = req_norm[i];
      end
   end

   // ---------------------------------------------------------------- S2
   logic signed [SQ_W-1:0] s2_ldsq_in [3];
   logic signed [SQ_W-1:0] s2_vvsq_in [3];
   logic [SQ_W-1:0]        s2_ldsq_ff [3];
   logic [SQ_W-1:0]        s2_vvsq_ff [3];
   side1_type              s2_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_ldsq_in[i] = SQ_W'($signed(s1_side_ff.ld[i])) * SQ_W'($signed(s1_side_ff.ld[i]));
         s2_vvsq_in[i] = SQ_W'($signed(s1_side_ff.vv[i])) * SQ_W'($signed(s1_side_ff.vv[i]));
      end
   end

   // ---------------------------------------------------------------- S3
   logic [SQ_W-1:0] s3_ssum_ff;
   logic [SQ_W-1:0] s3_vsum_ff;
   side1_type       s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
         s2_side_ff.valid <= 1'b0;
         s3_side_ff.valid <= 1'b0;
      end else if (en) begin
         s1_side_ff <= s1_side_in;
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s2_ldsq_ff[i] <= s2_ldsq_in[i];
            s2_vvsq_ff[i] <= s2_vvsq_in[i];
         end
         s3_ssum_ff <= s2_ldsq_ff[0] + s2_ldsq_ff[1] + s2_ldsq_ff[2];
         s3_vsum_ff <= s2_vvsq_ff[0] + s2_vvsq_ff[1] + s2_vvsq_ff[2];
      end
   end

   // ------------------------------------------------------ square roots
   logic [ROOT_W-1:0] s_root;
   logic [ROOT_W-1:0] q_root;
   side1_type         d1_ff [ROOT_W];
   side1_type         t1;

   vsa_isqrt #(.IN_W(SQ_W)) u_sqrt_l (
      .clock    (clock),
      .en       (en),
      .radicand (s3_ssum_ff),
      .root     (s_root)
   );

   vsa_isqrt #(.IN_W(SQ_W)) u_sqrt_v (
      .clock    (clock),
      .en       (en),
      .radicand (s3_vsum_ff),
      .root     (q_root)
   );

   for (genvar k = 0; k < ROOT_W; k++) begin : g_d1
      always_ff @(posedge clock) begin
         if (reset) begin
            d1_ff[k].valid <= 1'b0;
         end else if (en) begin
            if (k == 0) begin
               d1_ff[k] <= s3_side_ff;
            end else begin
               d1_ff[k] <= d1_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign t1 = d1_ff[ROOT_W-1];

   // ------------------------------------------- light normalization
   logic [DIFF_W-1:0] l_mag  [3];
   logic [LDIV_W-1:0] l_num  [3];
   logic [LQ_W-1:0]   l_quo  [3];
   side2_type         d2_src;
   side2_type         d2_ff  [LQ_W];
   side2_type         t2;

   always_comb begin
      d2_src.valid = t1.valid;
      d2_src.last  = t1.last;
      d2_src.szero = (s_root == '0);
      d2_src.vv    = t1.vv;
      d2_src.norm  = t1.norm;
      d2_src.q     = q_root;
      for (int i = 0; i < 3; i++) begin
         d2_src.neg[i] = t1.ld[i][DIFF_W-1];
         l_mag[i] = d2_src.neg[i] ? (DIFF_W'(0) - t1.ld[i]) : t1.ld[i];
         l_num[i] = LDIV_W'({l_mag[i], {FRAC_W{1'b0}}});
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_ldiv
      vsa_div #(.D_W(ROOT_W), .Q_W(LQ_W)) u_div_l (
         .clock    (clock),
         .en       (en),
         .dividend (l_num[i]),
         .divisor  (s_root),
         .quotient (l_quo[i])
      );
   end

   for (genvar k = 0; k < LQ_W; k++) begin : g_d2
      always_ff @(posedge clock) begin
         if (reset) begin
            d2_ff[k].valid <= 1'b0;
         end else if (en) begin
            if (k == 0) begin
               d2_ff[k] <= d2_src;
            end else begin
               d2_ff[k] <= d2_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign t2 = d2_ff[LQ_W-1];

   // ------------------------------------------ N.L and the reflection
   logic                     s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic                     s9_valid_ff, s10_valid_ff, s11_valid_ff, s12_valid_ff;
   logic                     s5_last_ff, s6_last_ff, s7_last_ff, s8_last_ff;
   logic                     s9_last_ff, s10_last_ff, s11_last_ff, s12_last_ff;

   logic signed [LV_W-1:0]   s5_l_in   [3];
   logic signed [LV_W-1:0]   s5_l_ff   [3];
   logic signed [LV_W-1:0]   s6_l_ff   [3];
   logic signed [LV_W-1:0]   s7_l_ff   [3];
   logic signed [LV_W-1:0]   s8_l_ff   [3];
   logic signed [NORM_W-1:0] s5_norm_ff [3];
   logic signed [NORM_W-1:0] s6_norm_ff [3];
   logic signed [NORM_W-1:0] s7_norm_ff [3];
   logic signed [DIFF_W-1:0] s5_vv_ff  [3];
   logic signed [DIFF_W-1:0] s6_vv_ff  [3];
   logic signed [DIFF_W-1:0] s7_vv_ff  [3];
   logic signed [DIFF_W-1:0] s8_vv_ff  [3];
   logic signed [DIFF_W-1:0] s9_vv_ff  [3];
   logic [ROOT_W-1:0]        s5_q_ff, s6_q_ff, s7_q_ff, s8_q_ff;
   logic [ROOT_W-1:0]        s9_q_ff, s10_q_ff, s11_q_ff, s12_q_ff;

   logic signed [PN_W-1:0]   s6_pn_ff  [3];
   logic signed [DSUM_W-1:0] s7_dsum_in;
   logic signed [NL_W-1:0]   s7_d_ff;
   logic signed [ND_W-1:0]   s8_nd_ff  [3];
   logic signed [R_W-1:0]    s9_r_in   [3];
   logic signed [R_W-1:0]    s9_r_ff   [3];
   logic signed [RV_W-1:0]   s10_rv_ff [3];
   logic signed [DOT_W-1:0]  s11_dot_ff;

   logic                     s12_pos_in, s12_sat_in;
   logic                     s12_pos_ff, s12_sat_ff;
   logic [ADIV_W-1:0]        s12_num_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         // Division truncates toward zero, so the sign goes back on the magnitude.
         if (t2.szero) begin
            s5_l_in[i] = '0;
         end else if (t2.neg[i]) begin
            s5_l_in[i] = LV_W'(0) - LV_W'(l_quo[i]);
         end else begin
            s5_l_in[i] = LV_W'(l_quo[i]);
         end
         s9_r_in[i] = R_W'(s8_nd_ff[i] >>> (FRAC_W - 1)) - R_W'(s8_l_ff[i]);
      end
      s7_dsum_in = DSUM_W'(s6_pn_ff[0]) + DSUM_W'(s6_pn_ff[1]) + DSUM_W'(s6_pn_ff[2]);
      s12_pos_in = !s11_dot_ff[DOT_W-1] && (s11_dot_ff != '0) && (s11_q_ff != '0);
      s12_sat_in = $unsigned(s11_dot_ff) >= DOT_W'({s11_q_ff, {FRAC_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff  <= t2.valid;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_last_ff  <= t2.last;
         s6_last_ff  <= s5_last_ff;
         s7_last_ff  <= s6_last_ff;
         s8_last_ff  <= s7_last_ff;
         s9_last_ff  <= s8_last_ff;
         s10_last_ff <= s9_last_ff;
         s11_last_ff <= s10_last_ff;
         s12_last_ff <= s11_last_ff;

         s5_q_ff  <= t2.q;
         s6_q_ff  <= s5_q_ff;
         s7_q_ff  <= s6_q_ff;
         s8_q_ff  <= s7_q_ff;
         s9_q_ff  <= s8_q_ff;
         s10_q_ff <= s9_q_ff;
         s11_q_ff <= s10_q_ff;
         s12_q_ff <= s11_q_ff;

         for (int i = 0; i < 3; i++) begin
            s5_l_ff[i]    <= s5_l_in[i];
            s5_norm_ff[i] <= $signed(t2.norm[i]);
            s5_vv_ff[i]   <= $signed(t2.vv[i]);

            s6_pn_ff[i]   <= PN_W'(s5_norm_ff[i]) * PN_W'(s5_l_ff[i]);
            s6_l_ff[i]    <= s5_l_ff[i];
            s6_norm_ff[i] <= s5_norm_ff[i];
            s6_vv_ff[i]   <= s5_vv_ff[i];

            s7_l_ff[i]    <= s6_l_ff[i];
            s7_norm_ff[i] <= s6_norm_ff[i];
            s7_vv_ff[i]   <= s6_vv_ff[i];

            s8_nd_ff[i]   <= ND_W'(s7_norm_ff[i]) * ND_W'(s7_d_ff);
            s8_l_ff[i]    <= s7_l_ff[i];
            s8_vv_ff[i]   <= s7_vv_ff[i];

            s9_r_ff[i]    <= s9_r_in[i];
            s9_vv_ff[i]   <= s8_vv_ff[i];

            s10_rv_ff[i]  <= RV_W'(s9_r_ff[i]) * RV_W'(s9_vv_ff[i]);
         end

         // Floor division by 2^14 is an arithmetic shift.
         s7_d_ff    <= NL_W'(s7_dsum_in >>> FRAC_W);
         s11_dot_ff <= DOT_W'(s10_rv_ff[0]) + DOT_W'(s10_rv_ff[1]) + DOT_W'(s10_rv_ff[2]);

         s12_pos_ff <= s12_pos_in;
         s12_sat_ff <= s12_sat_in;
         s12_num_ff <= ADIV_W'(s11_dot_ff);
      end
   end

   // ----------------------------------------------- l = R.V / |V|
   logic [AQ_W-1:0] a_quo;
   side3_type       d3_src;
   side3_type       d3_ff [AQ_W];
   side3_type       t3;

   vsa_div #(.D_W(ROOT_W), .Q_W(AQ_W)) u_div_a (
      .clock    (clock),
      .en       (en),
      .dividend (s12_num_ff),
      .divisor  (s12_q_ff),
      .quotient (a_quo)
   );

   always_comb begin
      d3_src.valid = s12_valid_ff;
      d3_src.last  = s12_last_ff;
      d3_src.pos   = s12_pos_ff;
      d3_src.sat   = s12_sat_ff;
   end

   for (genvar k = 0; k < AQ_W; k++) begin : g_d3
      always_ff @(posedge clock) begin
         if (reset) begin
            d3_ff[k].valid <= 1'b0;
         end else if (en) begin
            if (k == 0) begin
               d3_ff[k] <= d3_src;
            end else begin
               d3_ff[k] <= d3_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign t3 = d3_ff[AQ_W-1];

   // ------------------------------------------- l^4 * 255 / 2^56
   side3_type            s13_side_ff;
   side3_type            s14_side_ff;
   logic [L2_W-1:0]      s13_l2_ff;
   logic [L4_W-1:0]      s14_l4_ff;
   logic [SCALE_W-1:0]   s15_scaled;
   logic [ALPHA_W-1:0]   s15_alpha_in;
   logic                 s15_valid_ff;
   logic                 s15_last_ff;
   logic [ALPHA_W-1:0]   s15_alpha_ff;

   always_comb begin
      // Times 255 is times 256 minus once.
      s15_scaled = {s14_l4_ff, {ALPHA_W{1'b0}}} - SCALE_W'(s14_l4_ff);
      priority if (!s14_side_ff.pos) begin
         s15_alpha_in = '0;
      end else if (s14_side_ff.sat) begin
         s15_alpha_in = ALPHA_MAX;
      end else begin
         s15_alpha_in = s15_scaled[SCALE_W-1 -: ALPHA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s13_side_ff.valid <= 1'b0;
         s14_side_ff.valid <= 1'b0;
         s15_valid_ff      <= 1'b0;
      end else if (en) begin
         s13_side_ff  <= t3;
         s14_side_ff  <= s13_side_ff;
         s15_valid_ff <= s14_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s13_l2_ff    <= L2_W'(a_quo) * L2_W'(a_quo);
         s14_l4_ff    <= L4_W'(s13_l2_ff) * L4_W'(s13_l2_ff);
         s15_alpha_ff <= s15_alpha_in;
         s15_last_ff  <= s14_side_ff.last;
      end
   end

   // ------------------------------------------- output and skid stage
   logic                 out_valid_ff;
   logic [ALPHA_W-1:0]   out_alpha_ff;
   logic                 out_last_ff;
   logic [ALPHA_W-1:0]   skid_alpha_ff;
   logic                 skid_last_ff;
   logic                 out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= s15_valid_ff;
         end
      end else if (s15_valid_ff && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_alpha_ff <= skid_alpha_ff;
            out_last_ff  <= skid_last_ff;
         end else begin
            out_alpha_ff <= s15_alpha_ff;
            out_last_ff  <= s15_last_ff;
         end
      end else if (en) begin
         skid_alpha_ff <= s15_alpha_ff;
         skid_last_ff  <= s15_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_spec_alpha = out_alpha_ff;
   assign rsp_last_out   = out_last_ff;

   // ---------------------------------------------------------- checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> ($stable(s15_valid_ff) && $stable(s15_alpha_ff)))
      else $error("pipeline moved while the skid stage was full");

   a_no_light: assert property (@(posedge clock) disable iff (reset)
      (en && s14_side_ff.valid && !s14_side_ff.pos) |=> (s15_alpha_ff == '0))
      else $error("item facing away from the viewer gave a nonzero alpha");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      (en && s14_side_ff.valid && s14_side_ff.pos && s14_side_ff.sat)
         |=> (s15_alpha_ff == ALPHA_MAX))
      else $error("saturated item did not give full alpha");

endmodule
`default_nettype wire

// ===== tb/vsa_alpha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsa_alpha_checker
// Watches the vertex and result channels and the register port of the
// specular alpha core, predicts the alpha of every accepted vertex and
// compares it in order with every accepted result.
// ----------------------------------------------------------------------------
module vsa_alpha_checker import vsa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [POS_W-1:0]     req_pos_x,
   input  logic signed [POS_W-1:0]     req_pos_y,
   input  logic signed [POS_W-1:0]     req_pos_z,
   input  logic signed [NORM_W-1:0]    req_norm_x,
   input  logic signed [NORM_W-1:0]    req_norm_y,
   input  logic signed [NORM_W-1:0]    req_norm_z,
   input  logic                        req_last_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [ALPHA_W-1:0]          rsp_spec_alpha,
   input  logic                        rsp_last_out,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [POS_W-1:0]            csr_wdata,
   output int                          fail_count,
   output int                          pending
);

   typedef struct {
      logic [ALPHA_W-1:0] alpha;
      logic               last;
   } alpha_item_type;

   logic signed [POS_W-1:0] light_reg [3];
   logic signed [POS_W-1:0] eye_reg [3];
   alpha_item_type          alpha_queue [$];

   function automatic longint unsigned root_floor(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [ALPHA_W-1:0] spec_alpha_of(longint p[3], longint n[3]);
      longint          ld[3], vv[3], lv[3], rv[3];
      longint unsigned s2, v2, s, q, l2;
      longint          dsum, d, rdotv, l;
      s2 = 0; v2 = 0; dsum = 0; rdotv = 0;
      for (int i = 0; i < 3; i++) begin
         ld[i] = longint'(light_reg[i]) - p[i];
         vv[i] = longint'(eye_reg[i]) - p[i];
         s2 += ld[i] * ld[i];
         v2 += vv[i] * vv[i];
      end
      s = root_floor(s2);
      for (int i = 0; i < 3; i++) lv[i] = (s == 0) ? 0 : (ld[i] * 16384) / longint'(s);
      for (int i = 0; i < 3; i++) dsum += n[i] * lv[i];
      // Arithmetic shift gives the floor of the Q1.14 rescale.
      d = dsum >>> FRAC_W;
      for (int i = 0; i < 3; i++) begin
         rv[i] = ((2 * n[i] * d) >>> FRAC_W) - lv[i];
         rdotv += rv[i] * vv[i];
      end
      q = root_floor(v2);
      if (q == 0) return '0;
      l = rdotv / longint'(q);
      if (l >= 16384) return ALPHA_MAX;
      if (l <= 0) return '0;
      l2 = longint'(l) * longint'(l);
      return ALPHA_W'((l2 * l2 * 255) >> 56);
   endfunction

   always @(posedge clock) begin
      longint         p[3], n[3];
      alpha_item_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         light_reg[0] <= LIGHT_X_RESET;
         light_reg[1] <= LIGHT_Y_RESET;
         light_reg[2] <= LIGHT_Z_RESET;
         for (int i = 0; i < 3; i++) eye_reg[i] <= EYE_RESET;
         alpha_queue.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LIGHT_X: light_reg[0] <= csr_wdata;
               CSR_LIGHT_Y: light_reg[1] <= csr_wdata;
               CSR_LIGHT_Z: light_reg[2] <= csr_wdata;
               CSR_EYE_X:   eye_reg[0] <= csr_wdata;
               CSR_EYE_Y:   eye_reg[1] <= csr_wdata;
               CSR_EYE_Z:   eye_reg[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            p[0] = req_pos_x;  p[1] = req_pos_y;  p[2] = req_pos_z;
            n[0] = req_norm_x; n[1] = req_norm_y; n[2] = req_norm_z;
            want.alpha = spec_alpha_of(p, n);
            want.last = req_last_in;
            alpha_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (alpha_queue.size() == 0) begin
               $error("result item with no vertex outstanding");
               errs++;
            end else begin
               want = alpha_queue.pop_front();
               if (rsp_spec_alpha !== want.alpha) begin
                  $error("spec_alpha expected %0d got %0d", want.alpha, rsp_spec_alpha);
                  errs++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out expected %0d got %0d", want.last, rsp_last_out);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
         pending <= alpha_queue.size();
      end
   end

endmodule

// ===== tb/vertex_specular_alpha_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_specular_alpha_core_tb
// Drives directed and random vertices under several light and eye settings
// with random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module vertex_specular_alpha_core_tb import vsa_pkg::*;;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int POS_MAX = 16777215;
   localparam int POS_MIN = -16777216;
   localparam int UNIT = 16384;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [POS_W-1:0]  req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [NORM_W-1:0] req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   logic                     req_last_in = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [ALPHA_W-1:0]       rsp_spec_alpha;
   logic                     rsp_last_out;
   logic                     csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [POS_W-1:0]         csr_wdata = '0;

   int fail_count, pending;
   int send_pct = 0, recv_pct = 0;
   int cycle_count = 0, hold_count = 0;
   logic pressure_on = 1'b0, pressure_done = 1'b0;
   logic signed [POS_W-1:0] light_now [3], eye_now [3];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   vertex_specular_alpha_core DUT (.*);

   vsa_alpha_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off so the pipeline fills.
   always @(posedge clock) begin
      if (pressure_on && !pressure_done) begin
         rsp_stall <= 1'b1;
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES) pressure_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic signed [POS_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx < CSR_COUNT && idx < 3) light_now[idx] = val;
      else if (idx < CSR_COUNT) eye_now[idx - 3] = val;
   endtask

   task automatic set_scene(logic signed [POS_W-1:0] lx, ly, lz, ex, ey, ez);
      write_reg(CSR_LIGHT_X, lx);
      write_reg(CSR_LIGHT_Y, ly);
      write_reg(CSR_LIGHT_Z, lz);
      write_reg(CSR_EYE_X, ex);
      write_reg(CSR_EYE_Y, ey);
      write_reg(CSR_EYE_Z, ez);
   endtask

   task automatic send_vertex(logic signed [POS_W-1:0] px, py, pz,
                              logic signed [NORM_W-1:0] nx, ny, nz, logic last);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_norm_x <= nx; req_norm_y <= ny; req_norm_z <= nz;
      req_last_in <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Lowers valid and waits until every vertex has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || rsp_valid) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [POS_W-1:0] rand_pos();
      if ($urandom_range(3) == 0) return POS_W'($urandom);
      return POS_W'($signed($urandom_range(8192 * 256)) - 4096 * 256);
   endfunction

   function automatic logic signed [NORM_W-1:0] rand_norm();
      if ($urandom_range(19) == 0) return NORM_W'($urandom);
      return NORM_W'($signed($urandom_range(2 * UNIT)) - UNIT);
   endfunction

   task automatic random_vertex();
      logic signed [POS_W-1:0] p [3];
      logic signed [NORM_W-1:0] n [3];
      int pick;
      for (int i = 0; i < 3; i++) begin
         p[i] = rand_pos();
         n[i] = rand_norm();
      end
      pick = $urandom_range(39);
      if (pick == 0) p = light_now;
      else if (pick == 1) p = eye_now;
      else if (pick == 2) begin
         // A normal along one axis, the common case for flat faces.
         n[0] = 0; n[1] = 0; n[2] = 0;
         n[$urandom_range(2)] = $urandom_range(1) ? UNIT : -UNIT;
      end
      send_vertex(p[0], p[1], p[2], n[0], n[1], n[2], $urandom_range(7) == 0);
   endtask

   task automatic random_phase(int count, bit with_hold);
      set_scene(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_pos());
      for (int k = 0; k < count; k++) begin
         if (with_hold && k == 100) pressure_on <= 1'b1;
         random_vertex();
      end
      drain();
   endtask

   initial begin
      light_now[0] = LIGHT_X_RESET;
      light_now[1] = LIGHT_Y_RESET;
      light_now[2] = LIGHT_Z_RESET;
      for (int i = 0; i < 3; i++) eye_now[i] = EYE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vertices under the reset scene.
      send_vertex(0, 0, 0, 0, 0, UNIT, 1'b0);
      send_vertex(256, 512, -256, 0, UNIT, 0, 1'b0);
      send_vertex(POS_MAX, POS_MAX, POS_MAX, UNIT, UNIT, UNIT, 1'b1);
      send_vertex(POS_MIN, POS_MIN, POS_MIN, -UNIT, -UNIT, -UNIT, 1'b0);
      send_vertex(POS_MAX, POS_MIN, 0, 32767, -32768, 0, 1'b1);
      send_vertex(1000, -2000, 300, -32768, -32768, -32768, 1'b0);
      send_vertex(1000, -2000, 300, 32767, 32767, 32767, 1'b0);
      send_vertex(LIGHT_X_RESET, LIGHT_Y_RESET, LIGHT_Z_RESET, 0, UNIT, 0, 1'b0);
      send_vertex(-245760, 0, 24576, -UNIT, 0, 0, 1'b1);
      send_vertex(-5000, 1000, 0, 0, 0, -UNIT, 1'b0);
      drain();

      // Extreme scene, then the out-of-range register indexes.
      set_scene(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
      write_reg(CSR_IDX_W'(CSR_COUNT), POS_MIN);
      write_reg(CSR_IDX_W'(CSR_COUNT + 1), POS_MAX);
      send_vertex(0, 0, 0, 11585, 11585, 0, 1'b0);
      send_vertex(POS_MAX, POS_MAX, POS_MAX, UNIT, 0, 0, 1'b1);
      send_vertex(POS_MIN, POS_MIN, POS_MIN, 0, 0, UNIT, 1'b0);
      send_vertex(POS_MIN, POS_MAX, POS_MIN, -UNIT, UNIT, -UNIT, 1'b1);
      drain();

      // Light at the same place as a mirror-facing eye gives a saturated highlight.
      set_scene(0, 0, 25600, POS_MIN, POS_MIN, POS_MIN);
      set_scene(0, 0, 25600, 0, 0, 25600);
      send_vertex(0, 0, 0, 0, 0, UNIT, 1'b0);
      send_vertex(0, 0, 0, 0, 0, -UNIT, 1'b1);
      send_vertex(256, 0, 0, 0, 0, UNIT, 1'b0);
      drain();

      send_pct = 26; recv_pct = 54;
      random_phase(410, 1'b0);
      send_pct = 54; recv_pct = 26;
      random_phase(410, 1'b0);
      send_pct = 0; recv_pct = 0;
      random_phase(410, 1'b1);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
